[hw/rtl/hmq_pkg.sv]
`timescale 1ns / 1ps

package hmq_pkg;

  // field widths
  localparam int unsigned KeyW   = 32;
  localparam int unsigned SymW   = 8;
  localparam int unsigned OccW   = 7;
  localparam int unsigned StatW  = 2;

  // default number of heap slots
  localparam int unsigned CapacityDef = 64;

  // operation codes
  localparam logic ModeInsert  = 1'b0;
  localparam logic ModeExtract = 1'b1;

  // status codes
  localparam logic [StatW-1:0] StatDone  = 2'd0;
  localparam logic [StatW-1:0] StatFull  = 2'd1;
  localparam logic [StatW-1:0] StatEmpty = 2'd2;

  // one heap slot
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [SymW-1:0] sym;
  } entry_t;

endpackage

[hw/rtl/hmq_mem.sv]
`timescale 1ns / 1ps

module hmq_mem #(
  parameter int unsigned Depth = hmq_pkg::CapacityDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  hmq_pkg::entry_t      wdata_i,
  input  logic [AddrW-1:0]     raddr_a_i,
  input  logic [AddrW-1:0]     raddr_b_i,
  output hmq_pkg::entry_t      rdata_a_o,
  output hmq_pkg::entry_t      rdata_b_o
);

  hmq_pkg::entry_t mem_q [Depth];
  hmq_pkg::entry_t rd_a_q;
  hmq_pkg::entry_t rd_b_q;

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_a_q <= mem_q[raddr_a_i];
    rd_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

[hw/rtl/hmq_ctrl.sv]
`timescale 1ns / 1ps

module hmq_ctrl #(
  parameter int unsigned Capacity = hmq_pkg::CapacityDef,
  parameter int unsigned IdxW     = $clog2(Capacity),
  parameter int unsigned CntW     = $clog2(Capacity + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [hmq_pkg::KeyW-1:0]      key_freq_i,
  input  logic [hmq_pkg::SymW-1:0]      symbol_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hmq_pkg::StatW-1:0]     status_o,
  output logic [hmq_pkg::KeyW-1:0]      out_freq_o,
  output logic [hmq_pkg::SymW-1:0]      out_symbol_o,
  output logic [hmq_pkg::OccW-1:0]      occupancy_o,
  // heap memory
  output logic                          we_o,
  output logic [IdxW-1:0]               waddr_o,
  output hmq_pkg::entry_t               wdata_o,
  output logic [IdxW-1:0]               raddr_a_o,
  output logic [IdxW-1:0]               raddr_b_o,
  input  hmq_pkg::entry_t               rdata_a_i,
  input  hmq_pkg::entry_t               rdata_b_i
);

  localparam int unsigned ChW  = IdxW + 2;
  localparam int unsigned OccW = hmq_pkg::OccW;

  // sequencer states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StUp   = 3'd1;
  localparam logic [2:0] StEx0  = 3'd2;
  localparam logic [2:0] StDown = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  hmq_pkg::entry_t             ent_q, ent_d;
  logic [hmq_pkg::StatW-1:0]   pst_q, pst_d;
  hmq_pkg::entry_t             pout_q, pout_d;
  logic [hmq_pkg::StatW-1:0]   status_q, status_d;
  hmq_pkg::entry_t             oent_q, oent_d;
  logic [OccW-1:0]             occ_q, occ_d;

  logic [IdxW-1:0]             cnt_lo;
  logic [IdxW-1:0]             cnt_lo_m1;
  logic [IdxW-1:0]             idx_m1;
  logic [IdxW-1:0]             par;
  logic [IdxW-1:0]             par_m1;
  logic [ChW-1:0]              cnt_x;
  logic [ChW-1:0]              lch, rch;
  logic                        take_l, take_r;
  logic [hmq_pkg::KeyW-1:0]    best_key;
  logic [IdxW-1:0]             nidx;
  logic [ChW-1:0]              nl, nr;
  logic                        out_free;

  // index arithmetic for the heap tree
  always_comb begin
    cnt_lo    = cnt_q[IdxW-1:0];
    cnt_lo_m1 = cnt_lo - IdxW'(1);
    idx_m1    = idx_q - IdxW'(1);
    par       = idx_m1 >> 1;
    par_m1    = par - IdxW'(1);
    cnt_x     = ChW'(cnt_q);
    lch       = (ChW'(idx_q) << 1) + ChW'(1);
    rch       = lch + ChW'(1);
    take_l    = (lch < cnt_x) && (rdata_a_i.key < ent_q.key);
    best_key  = take_l ? rdata_a_i.key : ent_q.key;
    take_r    = (rch < cnt_x) && (rdata_b_i.key < best_key);
    nidx      = take_r ? rch[IdxW-1:0] : lch[IdxW-1:0];
    nl        = (ChW'(nidx) << 1) + ChW'(1);
    nr        = nl + ChW'(1);
    out_free  = !out_valid_q || out_ready_i;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    ent_d       = ent_q;
    pst_d       = pst_q;
    pout_d      = pout_q;
    status_d    = status_q;
    oent_d      = oent_q;
    occ_d       = occ_q;
    out_valid_d = out_valid_q && !out_ready_i;
    we_o        = 1'b0;
    waddr_o     = idx_q;
    wdata_o     = ent_q;
    raddr_a_o   = '0;
    raddr_b_o   = '0;
    in_ready_o  = (state_q == StIdle);

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ent_d.key = key_freq_i;
          ent_d.sym = symbol_i;
          pst_d     = hmq_pkg::StatDone;
          pout_d    = '0;
          if (mode_i == hmq_pkg::ModeInsert) begin
            if (cnt_q >= CntW'(Capacity)) begin
              pst_d   = hmq_pkg::StatFull;
              state_d = StFin;
            end else begin
              // hole starts at the first free slot, fetch its parent
              idx_d     = cnt_lo;
              raddr_a_o = cnt_lo_m1 >> 1;
              state_d   = StUp;
            end
          end else begin
            if (cnt_q == '0) begin
              pst_d   = hmq_pkg::StatEmpty;
              state_d = StFin;
            end else begin
              // fetch root and last entry together
              raddr_a_o = '0;
              raddr_b_o = cnt_lo_m1;
              cnt_d     = cnt_q - CntW'(1);
              state_d   = StEx0;
            end
          end
        end
      end

      StUp: begin
        we_o    = 1'b1;
        waddr_o = idx_q;
        if (idx_q == '0 || !(ent_q.key < rdata_a_i.key)) begin
          // new item settles in the hole
          wdata_o = ent_q;
          cnt_d   = cnt_q + CntW'(1);
          state_d = StFin;
        end else begin
          // parent moves down, hole climbs one level
          wdata_o   = rdata_a_i;
          idx_d     = par;
          raddr_a_o = par_m1 >> 1;
        end
      end

      StEx0: begin
        pout_d = rdata_a_i;
        ent_d  = rdata_b_i;
        if (cnt_q == '0) begin
          state_d = StFin;
        end else begin
          idx_d     = '0;
          raddr_a_o = IdxW'(1);
          raddr_b_o = IdxW'(2);
          state_d   = StDown;
        end
      end

      StDown: begin
        we_o    = 1'b1;
        waddr_o = idx_q;
        if (take_r || take_l) begin
          // smaller child moves up, hole sinks one level
          wdata_o   = take_r ? rdata_b_i : rdata_a_i;
          idx_d     = nidx;
          raddr_a_o = nl[IdxW-1:0];
          raddr_b_o = nr[IdxW-1:0];
        end else begin
          wdata_o = ent_q;
          state_d = StFin;
        end
      end

      StFin: begin
        // hand the result to the output register once it is free
        if (out_free) begin
          status_d    = pst_q;
          oent_d      = pout_q;
          occ_d       = OccW'(cnt_q);
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    ent_q    <= ent_d;
    pst_q    <= pst_d;
    pout_q   <= pout_d;
    status_q <= status_d;
    oent_q   <= oent_d;
    occ_q    <= occ_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_freq_o   = oent_q.key;
  assign out_symbol_o = oent_q.sym;
  assign occupancy_o  = occ_q;

endmodule

[hw/rtl/binary_min_heap_queue.sv]
// Sequence: an accepted insert reads the parent, then sifts the entry up one level per
//   step (StUp) and registers its result in StFin; an accepted extract reads root and
//   last entry, takes them in StEx0 (straight to StFin when it empties the heap), then
//   sifts down (StDown) before StFin. An entry moves up to log2(CAPACITY) levels, 6 at
//   64 slots; a refused insert or extract goes straight to StFin. One item at a time:
//   the next is taken once the result is registered; each level is one registered read.
// Reset: item count and control clear at once; result registers and heap slots are not reset.
`timescale 1ns / 1ps

module binary_min_heap_queue #(
  parameter int unsigned CAPACITY = hmq_pkg::CapacityDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [hmq_pkg::KeyW-1:0]      key_freq_i,
  input  logic [hmq_pkg::SymW-1:0]      symbol_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hmq_pkg::StatW-1:0]     status_o,
  output logic [hmq_pkg::KeyW-1:0]      out_freq_o,
  output logic [hmq_pkg::SymW-1:0]      out_symbol_o,
  output logic [hmq_pkg::OccW-1:0]      occupancy_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic              we;
  logic [IdxW-1:0]   waddr;
  hmq_pkg::entry_t   wdata;
  logic [IdxW-1:0]   raddr_a;
  logic [IdxW-1:0]   raddr_b;
  hmq_pkg::entry_t   rdata_a;
  hmq_pkg::entry_t   rdata_b;

  // sift sequencer and result register
  hmq_ctrl #(
    .Capacity (CAPACITY),
    .IdxW     (IdxW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .key_freq_i   (key_freq_i),
    .symbol_i     (symbol_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .out_freq_o   (out_freq_o),
    .out_symbol_o (out_symbol_o),
    .occupancy_o  (occupancy_o),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .raddr_a_o    (raddr_a),
    .raddr_b_o    (raddr_b),
    .rdata_a_i    (rdata_a),
    .rdata_b_i    (rdata_b)
  );

  // heap slot storage
  hmq_mem #(
    .Depth (CAPACITY),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

endmodule

[test/binary_min_heap_queue_checker.sv]
`timescale 1ns / 1ps

module binary_min_heap_queue_checker #(
  parameter int unsigned CAPACITY = hmq_pkg::CapacityDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      mode_i,
  input  logic [hmq_pkg::KeyW-1:0]  key_freq_i,
  input  logic [hmq_pkg::SymW-1:0]  symbol_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [hmq_pkg::StatW-1:0] status_i,
  input  logic [hmq_pkg::KeyW-1:0]  out_freq_i,
  input  logic [hmq_pkg::SymW-1:0]  out_symbol_i,
  input  logic [hmq_pkg::OccW-1:0]  occupancy_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o
);
  import hmq_pkg::*;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [KeyW-1:0]  freq;
    logic [SymW-1:0]  sym;
    logic [OccW-1:0]  occ;
  } heap_result_t;

  // shadow copy of the heap
  entry_t       heap_slots [CAPACITY];
  int unsigned  heap_size = 0;
  heap_result_t results_due [$];
  int unsigned  fails = 0;
  int unsigned  due_count = 0;

  assign fail_count_o = fails;
  assign pending_o    = due_count;

  // apply one item to the shadow heap and work out its result
  function automatic heap_result_t apply_item(logic op, logic [KeyW-1:0] key,
                                              logic [SymW-1:0] sym);
    heap_result_t res;
    int unsigned  pos;
    int unsigned  parent;
    int unsigned  best;
    int unsigned  left;
    int unsigned  right;
    entry_t       held;
    bit           settled;
    res        = '0;
    res.status = StatDone;
    if (op == ModeInsert) begin
      if (heap_size >= CAPACITY) begin
        res.status = StatFull;
      end else begin
        // sift up while strictly below the parent
        pos     = heap_size;
        settled = 1'b0;
        while (pos > 0 && !settled) begin
          parent = (pos - 1) / 2;
          if (key < heap_slots[parent].key) begin
            heap_slots[pos] = heap_slots[parent];
            pos             = parent;
          end else begin
            settled = 1'b1;
          end
        end
        heap_slots[pos].key = key;
        heap_slots[pos].sym = sym;
        heap_size++;
      end
    end else if (heap_size == 0) begin
      res.status = StatEmpty;
    end else begin
      res.freq = heap_slots[0].key;
      res.sym  = heap_slots[0].sym;
      heap_size--;
      heap_slots[0] = heap_slots[heap_size];
      // sift down, left child first, swap only on strict less-than
      pos     = 0;
      settled = 1'b0;
      while (!settled) begin
        best  = pos;
        left  = 2 * pos + 1;
        right = left + 1;
        if (left < heap_size && heap_slots[left].key < heap_slots[best].key)
          best = left;
        if (right < heap_size && heap_slots[right].key < heap_slots[best].key)
          best = right;
        if (best == pos) begin
          settled = 1'b1;
        end else begin
          held             = heap_slots[pos];
          heap_slots[pos]  = heap_slots[best];
          heap_slots[best] = held;
          pos              = best;
        end
      end
    end
    res.occ = OccW'(heap_size);
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  // predict on each accepted item, compare each accepted result
  always @(posedge clk_i) begin : watch
    heap_result_t due;
    if (!rst_ni) begin
      heap_size = 0;
      results_due.delete();
    end else begin
      if (in_valid_i && in_ready_i)
        results_due.push_back(apply_item(mode_i, key_freq_i, symbol_i));
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with no item outstanding, expected none, actual %0h %0h %0h %0h",
                   $time, status_i, out_freq_i, out_symbol_i, occupancy_i);
          fails++;
        end else begin
          due = results_due.pop_front();
          check_field("status", 64'(due.status), 64'(status_i));
          check_field("out_freq", 64'(due.freq), 64'(out_freq_i));
          check_field("out_symbol", 64'(due.sym), 64'(out_symbol_i));
          check_field("occupancy", 64'(due.occ), 64'(occupancy_i));
        end
      end
    end
    due_count = results_due.size();
  end

endmodule

[test/binary_min_heap_queue_tb.sv]
`timescale 1ns / 1ps

module binary_min_heap_queue_tb;
  import hmq_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 117;
  localparam int unsigned SettleCycles  = 20;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             mode;
  logic [KeyW-1:0]  key_freq;
  logic [SymW-1:0]  symbol;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [StatW-1:0] status;
  logic [KeyW-1:0]  out_freq;
  logic [SymW-1:0]  out_symbol;
  logic [OccW-1:0]  occupancy;

  int unsigned fails;
  int unsigned pending;
  int unsigned stall_pct = 25;
  int unsigned ready_hold = 0;
  int unsigned quiet_cycles = 0;

  binary_min_heap_queue #(
    .CAPACITY(CapacityDef)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (mode),
    .key_freq_i  (key_freq),
    .symbol_i    (symbol),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .out_freq_o  (out_freq),
    .out_symbol_o(out_symbol),
    .occupancy_o (occupancy)
  );

  binary_min_heap_queue_checker #(
    .CAPACITY(CapacityDef)
  ) heap_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .mode_i      (mode),
    .key_freq_i  (key_freq),
    .symbol_i    (symbol),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .status_i    (status),
    .out_freq_i  (out_freq),
    .out_symbol_i(out_symbol),
    .occupancy_i (occupancy),
    .fail_count_o(fails),
    .pending_o   (pending)
  );

  always #6 clk = ~clk;

  // result side stalls in random bursts
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ready  <= 1'b0;
      ready_hold = $urandom_range(0, 14);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no item or result moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // offer one item, called and returning at a falling edge
  task automatic send_item(logic op, logic [KeyW-1:0] key, logic [SymW-1:0] sym);
    int unsigned gap;
    gap = 0;
    if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
      gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    key_freq <= key;
    symbol   <= sym;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // random item, keys often tiny or extreme to force ties and corners
  task automatic send_random(int unsigned insert_pct);
    logic [KeyW-1:0] key;
    case ($urandom_range(0, 7))
      0, 1:    key = $urandom_range(0, 7);
      2:       key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: key = $urandom;
    endcase
    send_item(($urandom_range(0, 99) < insert_pct) ? ModeInsert : ModeExtract, key,
              SymW'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned insert_pct;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    mode     = ModeInsert;
    key_freq = '0;
    symbol   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty extract, extreme keys and symbols, equal keys, drain past empty
    send_item(ModeExtract, $urandom, SymW'($urandom_range(0, 255)));
    send_item(ModeInsert, 32'hFFFF_FFFF, 8'hFF);
    send_item(ModeInsert, 32'h0, 8'h00);
    send_item(ModeInsert, 32'd5, 8'hA5);
    send_item(ModeInsert, 32'd5, 8'h5A);
    send_item(ModeInsert, 32'd5, 8'h3C);
    send_item(ModeInsert, 32'h0, 8'h11);
    send_item(ModeInsert, 32'h8000_0000, 8'h80);
    send_item(ModeInsert, 32'd1, 8'h01);
    repeat (9) send_item(ModeExtract, $urandom, SymW'($urandom_range(0, 255)));

    // hold off until the block has answered everything
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);

    // random phases alternate filling and draining, the last one without idling
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       begin insert_pct = 90; stall_pct = 25; end
        1:       begin insert_pct = 15; stall_pct = 50; end
        2:       begin insert_pct = 90; stall_pct = 0;  end
        3:       begin insert_pct = 50; stall_pct = 25; end
        4:       begin insert_pct = 10; stall_pct = 50; end
        default: begin insert_pct = 60; stall_pct = 0;  end
      endcase
      repeat (PhaseItems) send_random(insert_pct);
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/hmq_pkg.sv
hw/rtl/hmq_mem.sv
hw/rtl/hmq_ctrl.sv
hw/rtl/binary_min_heap_queue.sv
test/binary_min_heap_queue_checker.sv
test/binary_min_heap_queue_tb.sv
